// ----- rtl/log_spectrum_hps_peak_finder_core_defines.svh -----
// ----------------------------------------------------------------------------
// Harmonic peak finder assertion macros
// Shared property forms for the checker: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef LOG_SPECTRUM_HPS_PEAK_FINDER_CORE_DEFINES_SVH
`define LOG_SPECTRUM_HPS_PEAK_FINDER_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define LSHPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define LSHPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lshpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic peak finder package
// Field widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package lshpf_pkg;

  localparam int PEAK_BIN_W = 8;
  localparam int OFFSET_W   = 7;
  localparam int SCORE_W    = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int LOW_W      = 8;
  localparam int HIGH_W     = 9;
  localparam int SHIFT_W    = 8;
  localparam int FRAC_BITS  = 5;
  localparam int QUOT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_THIRD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_FOURTH = 3'd4;

  localparam logic [LOW_W-1:0]   RST_SEARCH_LOW   = 8'd2;
  localparam logic [HIGH_W-1:0]  RST_SEARCH_HIGH  = 9'd130;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_SECOND = 8'd26;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_THIRD  = 8'd41;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_FOURTH = 8'd51;

  // first quotient bit tested, and the clamp value of the offset
  localparam logic [2:0]        QUOT_TOP     = 3'd5;
  localparam logic [QUOT_W-1:0] OFFSET_LIMIT = 6'd32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_INTERP,
    ST_DIVIDE,
    ST_DONE
  } lshpf_state_t;

endpackage

// ----- rtl/lshpf_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic peak finder channel interfaces
// Bin input channel, peak result channel and register write channel.
// ----------------------------------------------------------------------------
interface lshpf_in_if #(
  parameter int BIN_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [BIN_BITS-1:0] bin_value;
  logic                frame_end;

  modport source (output valid, output bin_value, output frame_end, input ready);
  modport sink   (input valid, input bin_value, input frame_end, output ready);
endinterface

interface lshpf_out_if;
  import lshpf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [PEAK_BIN_W-1:0]      peak_bin;
  logic signed [OFFSET_W-1:0] peak_offset;
  logic [SCORE_W-1:0]         peak_score;
  logic                       interp_valid;

  modport source (output valid, output peak_bin, output peak_offset, output peak_score,
                  output interp_valid, input ready);
  modport sink   (input valid, input peak_bin, input peak_offset, input peak_score,
                  input interp_valid, output ready);
endinterface

interface lshpf_cfg_if;
  import lshpf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/log_spectrum_hps_peak_finder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic sum peak finder over a log-spaced spectrum frame
// Stores one bin per beat; on the last bin searches for the highest sum of a
// bin and three harmonic bins, then refines the peak with a parabola fit.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | handshake
//  in_ch    | in  | bin_value, frame_end                            | valid/ready
//  out_ch   | out | peak_bin, peak_offset, peak_score, interp_valid | valid/ready
//  cfg_ch   | in  | index, data                                     | valid/ready
//
//  A bin without frame_end is written to the store and in_ch.ready stays
//  high. On the last bin the block searches the window bin by bin over the
//  single store read port, makes the three neighbour reads, runs the
//  bit-serial offset divide and then loads the result register. After
//  reset the store is cleared one entry a cycle with in_ch.ready low. A
//  stalled result holds the block in its last step only.
// ----------------------------------------------------------------------------
module log_spectrum_hps_peak_finder_core #(
  parameter int NUM_BINS = 256,
  parameter int BIN_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  lshpf_in_if.sink    in_ch,
  lshpf_out_if.source out_ch,
  lshpf_cfg_if.sink   cfg_ch
);
  import lshpf_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int AW    = ((IDX_W > HIGH_W) ? IDX_W : HIGH_W) + 1;
  localparam int SW    = BIN_BITS + 2;
  localparam int DEN_W = BIN_BITS + 3;
  localparam int NUM_W = BIN_BITS + 1;
  localparam int RW    = BIN_BITS + 7;

  lshpf_state_t state_r, state_nxt;

  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]   load_idx_r, load_idx_nxt;
  logic [LOW_W-1:0]   search_low_r, search_low_nxt;
  logic [HIGH_W-1:0]  search_high_r, search_high_nxt;
  logic [SHIFT_W-1:0] shift_second_r, shift_second_nxt;
  logic [SHIFT_W-1:0] shift_third_r, shift_third_nxt;
  logic [SHIFT_W-1:0] shift_fourth_r, shift_fourth_nxt;

  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      end_r, end_nxt;
  logic [AW-1:0]      best_i_r, best_i_nxt;
  logic [SW-1:0]      best_s_r, best_s_nxt;
  logic [SW-1:0]      acc_r, acc_nxt;
  logic [2:0]         phase_r, phase_nxt;

  logic [BIN_BITS-1:0]    f0_r, f0_nxt;
  logic [BIN_BITS-1:0]    f1_r, f1_nxt;
  logic signed [DEN_W-1:0] den_r, den_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic [RW-1:0]          rem_r, rem_nxt;
  logic [RW-1:0]          dsh_r, dsh_nxt;
  logic [QUOT_W-1:0]      q_r, q_nxt;
  logic [2:0]             step_r, step_nxt;
  logic                   neg_r, neg_nxt;
  logic signed [OFFSET_W-1:0] res_off_r, res_off_nxt;
  logic                   res_ival_r, res_ival_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [PEAK_BIN_W-1:0]      out_bin_r, out_bin_nxt;
  logic signed [OFFSET_W-1:0] out_off_r, out_off_nxt;
  logic [SCORE_W-1:0]         out_score_r, out_score_nxt;
  logic                       out_ival_r, out_ival_nxt;

  logic [BIN_BITS-1:0] bin_store_r [NUM_BINS];
  logic [BIN_BITS-1:0] rd_data_r;
  logic                rd_zero_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [BIN_BITS-1:0] mem_wdata;

  logic [AW-1:0]       add_base;
  logic [AW-1:0]       add_opd;
  logic [AW-1:0]       addr_sum;
  logic                rd_oob;
  logic [BIN_BITS-1:0] rd_val;
  logic [SW-1:0]       acc_sum;
  logic [AW-1:0]       end_w;
  logic                in_acc;
  logic signed [DEN_W-1:0] den_w;
  logic signed [NUM_W-1:0] num_w;
  logic [NUM_W-1:0]    num_mag;
  logic [DEN_W-1:0]    den_mag;
  logic [RW:0]         div_diff;
  logic                div_hit;
  logic [QUOT_W-1:0]   q_w;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.peak_bin     = out_bin_r;
  assign out_ch.peak_offset  = out_off_r;
  assign out_ch.peak_score   = out_score_r;
  assign out_ch.interp_valid = out_ival_r;

  // shared index adder: harmonic and neighbour addresses, bin increment
  always_comb begin
    add_base = idx_r;
    add_opd  = '0;
    unique case (state_r)
      ST_SEARCH: begin
        case (phase_r)
          3'd1:    add_opd = AW'(shift_second_r);
          3'd2:    add_opd = AW'(shift_third_r);
          3'd3:    add_opd = AW'(shift_fourth_r);
          3'd4:    add_opd = AW'(1);
          default: add_opd = '0;
        endcase
      end
      ST_INTERP: begin
        add_base = best_i_r;
        case (phase_r)
          3'd0:    add_opd = '1;
          3'd2:    add_opd = AW'(1);
          default: add_opd = '0;
        endcase
      end
      default: add_opd = '0;
    endcase
  end

  assign addr_sum = add_base + add_opd;
  assign rd_oob   = (addr_sum >= AW'(NUM_BINS));
  assign rd_val   = rd_zero_r ? '0 : rd_data_r;
  assign acc_sum  = SW'(rd_val) + ((phase_r == 3'd1) ? '0 : acc_r);
  assign end_w    = (AW'(search_high_r) > AW'(NUM_BINS)) ? AW'(NUM_BINS)
                                                          : AW'(search_high_r);

  assign den_w = $signed({2'b00, f1_r, 1'b0}) - $signed({3'b000, f0_r})
               - $signed({3'b000, rd_val});
  assign num_w = $signed({1'b0, rd_val}) - $signed({1'b0, f0_r});

  assign num_mag  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign den_mag  = den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
  assign div_diff = {1'b0, rem_r} - {1'b0, dsh_r};
  assign div_hit  = !div_diff[RW];
  assign q_w      = {q_r[QUOT_W-2:0], div_hit};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_store_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bin_store_r[addr_sum[IDX_W-1:0]];
    rd_zero_r <= rd_oob;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    clr_idx_nxt      = clr_idx_r;
    load_idx_nxt     = load_idx_r;
    search_low_nxt   = search_low_r;
    search_high_nxt  = search_high_r;
    shift_second_nxt = shift_second_r;
    shift_third_nxt  = shift_third_r;
    shift_fourth_nxt = shift_fourth_r;
    idx_nxt          = idx_r;
    end_nxt          = end_r;
    best_i_nxt       = best_i_r;
    best_s_nxt       = best_s_r;
    acc_nxt          = acc_r;
    phase_nxt        = phase_r;
    f0_nxt           = f0_r;
    f1_nxt           = f1_r;
    den_nxt          = den_r;
    num_nxt          = num_r;
    rem_nxt          = rem_r;
    dsh_nxt          = dsh_r;
    q_nxt            = q_r;
    step_nxt         = step_r;
    neg_nxt          = neg_r;
    res_off_nxt      = res_off_r;
    res_ival_nxt     = res_ival_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_bin_nxt      = out_bin_r;
    out_off_nxt      = out_off_r;
    out_score_nxt    = out_score_r;
    out_ival_nxt     = out_ival_r;
    mem_we           = 1'b0;
    mem_waddr        = load_idx_r;
    mem_wdata        = in_ch.bin_value;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SEARCH_LOW:   search_low_nxt   = cfg_ch.data[LOW_W-1:0];
        CFG_SEARCH_HIGH:  search_high_nxt  = cfg_ch.data[HIGH_W-1:0];
        CFG_SHIFT_SECOND: shift_second_nxt = cfg_ch.data[SHIFT_W-1:0];
        CFG_SHIFT_THIRD:  shift_third_nxt  = cfg_ch.data[SHIFT_W-1:0];
        CFG_SHIFT_FOURTH: shift_fourth_nxt = cfg_ch.data[SHIFT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == IDX_W'(NUM_BINS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          mem_we = 1'b1;
          if (in_ch.frame_end) begin
            load_idx_nxt = '0;
            idx_nxt      = AW'(search_low_r);
            best_i_nxt   = AW'(search_low_r);
            best_s_nxt   = '0;
            end_nxt      = end_w;
            phase_nxt    = 3'd0;
            state_nxt    = (AW'(search_low_r) < end_w) ? ST_SEARCH : ST_INTERP;
          end else if (load_idx_r == IDX_W'(NUM_BINS - 1)) begin
            load_idx_nxt = '0;
          end else begin
            load_idx_nxt = load_idx_r + 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (phase_r == 3'd4) begin
          phase_nxt = 3'd0;
          if (acc_sum > best_s_r) begin
            best_s_nxt = acc_sum;
            best_i_nxt = idx_r;
          end
          if (addr_sum == end_r) begin
            state_nxt = ST_INTERP;
          end else begin
            idx_nxt = addr_sum;
          end
        end else begin
          if (phase_r != 3'd0) begin
            acc_nxt = acc_sum;
          end
          phase_nxt = phase_r + 1'b1;
        end
      end
      ST_INTERP: begin
        phase_nxt = phase_r + 1'b1;
        case (phase_r)
          3'd1: f0_nxt = rd_val;
          3'd2: f1_nxt = rd_val;
          3'd3: begin
            den_nxt = den_w;
            num_nxt = num_w;
          end
          3'd4: begin
            phase_nxt = 3'd0;
            if (den_r == '0) begin
              res_off_nxt  = '0;
              res_ival_nxt = 1'b0;
              state_nxt    = ST_DONE;
            end else begin
              rem_nxt      = RW'({num_mag, {FRAC_BITS{1'b0}}});
              dsh_nxt      = RW'({den_mag, {FRAC_BITS{1'b0}}});
              neg_nxt      = num_r[NUM_W-1] ^ den_r[DEN_W-1];
              q_nxt        = '0;
              step_nxt     = QUOT_TOP;
              res_ival_nxt = 1'b1;
              state_nxt    = ST_DIVIDE;
            end
          end
          default: ;
        endcase
      end
      ST_DIVIDE: begin
        dsh_nxt = dsh_r >> 1;
        if (div_hit) begin
          rem_nxt = div_diff[RW-1:0];
        end
        if (step_r == QUOT_TOP && div_hit) begin
          res_off_nxt = neg_r ? -OFFSET_W'(OFFSET_LIMIT) : OFFSET_W'(OFFSET_LIMIT);
          state_nxt   = ST_DONE;
        end else begin
          q_nxt = q_w;
          if (step_r == 3'd0) begin
            res_off_nxt = neg_r ? -OFFSET_W'(q_w) : OFFSET_W'(q_w);
            state_nxt   = ST_DONE;
          end else begin
            step_nxt = step_r - 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_bin_nxt   = PEAK_BIN_W'(best_i_r);
          out_off_nxt   = res_off_r;
          out_score_nxt = SCORE_W'(best_s_r);
          out_ival_nxt  = res_ival_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r      <= '0;
      load_idx_r     <= '0;
      search_low_r   <= RST_SEARCH_LOW;
      search_high_r  <= RST_SEARCH_HIGH;
      shift_second_r <= RST_SHIFT_SECOND;
      shift_third_r  <= RST_SHIFT_THIRD;
      shift_fourth_r <= RST_SHIFT_FOURTH;
      phase_r        <= '0;
      step_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      clr_idx_r      <= clr_idx_nxt;
      load_idx_r     <= load_idx_nxt;
      search_low_r   <= search_low_nxt;
      search_high_r  <= search_high_nxt;
      shift_second_r <= shift_second_nxt;
      shift_third_r  <= shift_third_nxt;
      shift_fourth_r <= shift_fourth_nxt;
      phase_r        <= phase_nxt;
      step_r         <= step_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    end_r       <= end_nxt;
    best_i_r    <= best_i_nxt;
    best_s_r    <= best_s_nxt;
    acc_r       <= acc_nxt;
    f0_r        <= f0_nxt;
    f1_r        <= f1_nxt;
    den_r       <= den_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    neg_r       <= neg_nxt;
    res_off_r   <= res_off_nxt;
    res_ival_r  <= res_ival_nxt;
    out_bin_r   <= out_bin_nxt;
    out_off_r   <= out_off_nxt;
    out_score_r <= out_score_nxt;
    out_ival_r  <= out_ival_nxt;
  end

endmodule

// ----- rtl/lshpf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic peak finder port checker
// Watches the core ports for result hold, offset range and input busy state.
// ----------------------------------------------------------------------------
`include "log_spectrum_hps_peak_finder_core_defines.svh"

module lshpf_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_frame_end,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [lshpf_pkg::PEAK_BIN_W-1:0]     out_peak_bin,
  input logic signed [lshpf_pkg::OFFSET_W-1:0] out_peak_offset,
  input logic [lshpf_pkg::SCORE_W-1:0]        out_peak_score,
  input logic                                 out_interp_valid
);
  import lshpf_pkg::*;

  `LSHPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_peak_bin) && $stable(out_peak_offset) && $stable(out_peak_score) && $stable(out_interp_valid), "result beat changed while stalled")
  `LSHPF_ASSERT_IMPL(a_offset_range, clk, rst_n, out_valid, (out_peak_offset >= -7'sd32) && (out_peak_offset <= 7'sd32), "peak offset outside half a bin")
  `LSHPF_ASSERT_IMPL(a_flat_offset, clk, rst_n, out_valid && !out_interp_valid, out_peak_offset == '0, "offset nonzero without interpolation")
  `LSHPF_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_valid && in_ready && in_frame_end, !in_ready, "input still ready after last bin")

endmodule

bind log_spectrum_hps_peak_finder_core lshpf_checker u_lshpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_frame_end     (in_ch.frame_end),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_peak_bin     (out_ch.peak_bin),
  .out_peak_offset  (out_ch.peak_offset),
  .out_peak_score   (out_ch.peak_score),
  .out_interp_valid (out_ch.interp_valid)
);

// ----- bench/log_spectrum_hps_peak_finder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic peak finder testbench
// Streams spectrum frames into the core under a series of search windows and
// harmonic offsets, including the extremes. A local copy of the bin store and
// registers predicts every peak result. Each result beat is checked field by
// field against the oldest prediction, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module log_spectrum_hps_peak_finder_core_tb;
  import lshpf_pkg::*;

  localparam int NUM_BINS      = 256;
  localparam int BIN_BITS      = 16;
  localparam int ITEM_TARGET   = 1650;
  localparam int PHASE_COUNT   = 10;
  localparam int MIN_FRAMES    = 40;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_CAP    = 50;
  localparam int OFFSET_SCALE  = 1 << FRAC_BITS;
  localparam int CFG_SLOTS     = 1 << CFG_IDX_W;

  typedef struct packed {
    logic [BIN_BITS-1:0] bin_value;
    logic                frame_end;
  } bin_beat_t;

  typedef struct packed {
    logic [PEAK_BIN_W-1:0]      peak_bin;
    logic signed [OFFSET_W-1:0] peak_offset;
    logic [SCORE_W-1:0]         peak_score;
    logic                       interp_valid;
  } peak_t;

  logic clk = 1'b0;
  logic rst_n;

  lshpf_in_if #(.BIN_BITS(BIN_BITS)) in_if ();
  lshpf_out_if                       out_if ();
  lshpf_cfg_if                       cfg_if ();

  log_spectrum_hps_peak_finder_core #(
    .NUM_BINS(NUM_BINS),
    .BIN_BITS(BIN_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  logic [BIN_BITS-1:0] spectrum_mem [NUM_BINS];
  int unsigned         write_ptr;
  logic [LOW_W-1:0]    cfg_lo;
  logic [HIGH_W-1:0]   cfg_hi;
  logic [SHIFT_W-1:0]  harm2_shift;
  logic [SHIFT_W-1:0]  harm3_shift;
  logic [SHIFT_W-1:0]  harm4_shift;

  bin_beat_t   bin_queue [$];
  peak_t       peak_queue [$];
  logic        in_fired  = 1'b0;
  logic        cfg_fired = 1'b0;
  int          burst_left = 1;
  int          gap_left   = 0;
  int          stall_left = 0;
  logic [31:0] stall_pat  = '1;
  int          errors         = 0;
  int          frames_checked = 0;
  int          bins_queued    = 0;
  int          frames_queued  = 0;
  int          cfg_writes     = 0;
  int          cycle_count    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned bin_at(input int unsigned idx);
    if (idx < NUM_BINS) return spectrum_mem[idx];
    return 0;
  endfunction

  function automatic peak_t predict_peak();
    int unsigned stop, idx, best_bin, total, best_total;
    logic        found;
    longint      lower_nb, centre, upper_nb, den, off;
    peak_t       r;
    stop       = (cfg_hi > NUM_BINS) ? NUM_BINS : cfg_hi;
    best_bin   = cfg_lo;
    best_total = 0;
    found      = 1'b0;
    for (idx = cfg_lo; idx < stop; idx++) begin
      total = bin_at(idx) + bin_at(idx + harm2_shift) + bin_at(idx + harm3_shift)
            + bin_at(idx + harm4_shift);
      if (!found || total > best_total) begin
        best_total = total;
        best_bin   = idx;
        found      = 1'b1;
      end
    end
    lower_nb = (best_bin > 0) ? longint'(bin_at(best_bin - 1)) : 0;
    centre   = bin_at(best_bin);
    upper_nb = bin_at(best_bin + 1);
    den      = 2 * centre - lower_nb - upper_nb;
    off      = 0;
    if (den != 0) begin
      off = (OFFSET_SCALE * (upper_nb - lower_nb)) / den;
      if (off < -OFFSET_SCALE) off = -OFFSET_SCALE;
      if (off > OFFSET_SCALE) off = OFFSET_SCALE;
    end
    r.peak_bin     = best_bin[PEAK_BIN_W-1:0];
    r.peak_offset  = off[OFFSET_W-1:0];
    r.peak_score   = best_total[SCORE_W-1:0];
    r.interp_valid = (den != 0);
    return r;
  endfunction

  // track accepted beats and keep the local store and registers in step
  always @(posedge clk) begin
    in_fired  <= rst_n && in_if.valid && in_if.ready;
    cfg_fired <= rst_n && cfg_if.valid && cfg_if.ready;
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_SEARCH_LOW:   cfg_lo      = cfg_if.data[LOW_W-1:0];
        CFG_SEARCH_HIGH:  cfg_hi      = cfg_if.data[HIGH_W-1:0];
        CFG_SHIFT_SECOND: harm2_shift = cfg_if.data[SHIFT_W-1:0];
        CFG_SHIFT_THIRD:  harm3_shift = cfg_if.data[SHIFT_W-1:0];
        CFG_SHIFT_FOURTH: harm4_shift = cfg_if.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      spectrum_mem[write_ptr] = in_if.bin_value;
      write_ptr = (write_ptr + 1) % NUM_BINS;
      if (in_if.frame_end) begin
        write_ptr = 0;
        peak_queue.push_back(predict_peak());
      end
      void'(bin_queue.pop_front());
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    peak_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (peak_queue.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: peak beat with none expected, expected nothing, actual bin %0d",
                   $time, out_if.peak_bin);
      end else begin
        want = peak_queue.pop_front();
        frames_checked++;
        check_field("peak_bin", want.peak_bin, out_if.peak_bin);
        check_field("peak_offset", want.peak_offset, out_if.peak_offset);
        check_field("peak_score", want.peak_score, out_if.peak_score);
        check_field("interp_valid", want.interp_valid, out_if.interp_valid);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d bins and %0d peaks outstanding",
               cycle_count, bin_queue.size(), peak_queue.size());
      $display("log_spectrum_hps_peak_finder_core test failed");
      $finish;
    end
  end

  // bin source: bursts with random gaps, beat held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_fired)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (bin_queue.size() > 0) begin
        in_if.valid     <= 1'b1;
        in_if.bin_value <= bin_queue[0].bin_value;
        in_if.frame_end <= bin_queue[0].frame_end;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 3);
            2: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(0, 1);
          endcase
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink: rotate a stall pattern, reload it now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = '1;
        1: stall_pat = $urandom;
        2: stall_pat = $urandom & $urandom;
        default: stall_pat = $urandom | $urandom;
      endcase
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    out_if.ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[31:1]};
  end

  task automatic queue_bin(input logic [BIN_BITS-1:0] value, input logic closes);
    bin_beat_t beat;
    beat.bin_value = value;
    beat.frame_end = closes;
    bin_queue.push_back(beat);
    bins_queued++;
    if (closes) frames_queued++;
  endtask

  task automatic queue_frame(input int len, input logic closes);
    int                  k, style;
    logic [BIN_BITS-1:0] level, value;
    style = $urandom_range(0, 3);
    level = BIN_BITS'($urandom);
    for (k = 0; k < len; k++) begin
      case (style)
        0: value = BIN_BITS'($urandom);
        1: value = level;
        2: value = BIN_BITS'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 15));
        default: value = $urandom_range(0, 1) ? '1 : '0;
      endcase
      queue_bin(value, closes && (k == len - 1));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (bin_queue.size() != 0 || peak_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // call on a falling edge; returns on the falling edge after the beat is taken
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(negedge clk); while (!cfg_fired);
    cfg_writes++;
  endtask

  task automatic program_search(input logic [CFG_DATA_W-1:0] lo, hi, s2, s3, s4);
    cfg_write(CFG_SEARCH_LOW, lo);
    cfg_write(CFG_SEARCH_HIGH, hi);
    cfg_write(CFG_SHIFT_SECOND, s2);
    cfg_write(CFG_SHIFT_THIRD, s3);
    cfg_write(CFG_SHIFT_FOURTH, s4);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int                    k, phase, phase_start, len, spare;
    logic [CFG_DATA_W-1:0] lo_pick, hi_pick;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.bin_value = '0;
    in_if.frame_end = 1'b0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    for (k = 0; k < NUM_BINS; k++) spectrum_mem[k] = '0;
    write_ptr   = 0;
    cfg_lo      = RST_SEARCH_LOW;
    cfg_hi      = RST_SEARCH_HIGH;
    harm2_shift = RST_SHIFT_SECOND;
    harm3_shift = RST_SHIFT_THIRD;
    harm4_shift = RST_SHIFT_FOURTH;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lone bin 0, flat window: zero denominator
    queue_bin(16'hFFFF, 1'b1);
    // clear peak at bin 3 with uneven neighbours
    queue_bin(16'h0000, 1'b0);
    queue_bin(16'h1000, 1'b0);
    queue_bin(16'h4000, 1'b0);
    queue_bin(16'hFFFF, 1'b0);
    queue_bin(16'h8000, 1'b0);
    queue_bin(16'h0001, 1'b0);
    queue_bin(16'h7FFF, 1'b0);
    queue_bin(16'h5555, 1'b1);
    // tie between bins 3 and 4: keep the first, offset at the clamp
    queue_bin(16'h0000, 1'b0);
    queue_bin(16'h0000, 1'b0);
    queue_bin(16'h0000, 1'b0);
    queue_bin(16'hFFFF, 1'b0);
    queue_bin(16'hFFFF, 1'b0);
    queue_bin(16'hAAAA, 1'b1);

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: program_search(9'd0, 9'd256, 9'd0, 9'd0, 9'd0);
          2: program_search(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
          3: program_search(9'd200, 9'd100, 9'd300, 9'd5, 9'd255);
          4: begin
            for (spare = CFG_SHIFT_FOURTH + 1; spare < CFG_SLOTS; spare++)
              cfg_write(CFG_IDX_W'(spare), CFG_DATA_W'($urandom));
            program_search(9'd0, 9'd1, 9'd1, 9'd2, 9'd3);
          end
          default: begin
            lo_pick = CFG_DATA_W'($urandom_range(0, 511));
            case ($urandom_range(0, 4))
              0: hi_pick = CFG_DATA_W'(lo_pick[LOW_W-1:0]);
              1: hi_pick = CFG_DATA_W'($urandom_range(0, 511));
              default: hi_pick = CFG_DATA_W'(lo_pick[LOW_W-1:0] + $urandom_range(1, 40));
            endcase
            program_search(lo_pick, hi_pick,
                           CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 511)
                                                            : $urandom_range(0, 16)),
                           CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 511)
                                                            : $urandom_range(0, 16)),
                           CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 511)
                                                            : $urandom_range(0, 16)));
          end
        endcase
      end
      phase_start = bins_queued;
      if (phase == 2) queue_frame(NUM_BINS, 1'b1);
      while (bins_queued < (phase + 1) * ITEM_TARGET / PHASE_COUNT ||
             bins_queued == phase_start ||
             (phase == PHASE_COUNT - 1 && frames_queued < MIN_FRAMES)) begin
        case ($urandom_range(0, 19)) inside
          [0:15]:  len = $urandom_range(1, 16);
          [16:18]: len = $urandom_range(17, NUM_BINS - 1);
          default: len = $urandom_range(NUM_BINS, NUM_BINS + 34);
        endcase
        queue_frame(len, $urandom_range(0, 19) != 0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d bins in %0d closed frames over %0d settings, %0d register writes",
             bins_queued, frames_queued, PHASE_COUNT, cfg_writes);
    $display("checked %0d peak beats, %0d mismatches", frames_checked, errors);
    if (errors == 0 && peak_queue.size() == 0)
      $display("log_spectrum_hps_peak_finder_core test passed");
    else
      $display("log_spectrum_hps_peak_finder_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lshpf_pkg.sv
rtl/lshpf_intf.sv
rtl/log_spectrum_hps_peak_finder_core.sv
rtl/lshpf_checker.sv
bench/log_spectrum_hps_peak_finder_core_tb.sv
